/* sv/assert_macros.svh */
// Assertion macros shared by the chain ordering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion with an explicit clock and active-low reset.
`define COP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion on the block clock and reset.
`define COP_ASSERT(label, prop, msg) `COP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define COP_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define COP_ASSERT(label, prop, msg)
`endif
`endif

/* sv/cop_pkg.sv */
// Shared constants and types of the chain ordering block.
`default_nettype none
package cop_pkg;

  // Number of pair cells in the chain.
  localparam int unsigned CAPACITY = 64;
  // Width of an id.
  localparam int unsigned IdW = 16;
  // Width of a pair count that can hold CAPACITY itself.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Search transaction that travels down the cell chain.
  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] want;
    logic           found;
    logic [IdW-1:0] own;
  } query_t;

endpackage
`default_nettype wire

/* sv/cop_cell.sv */
// One pair cell: stores a pair and checks the passing search transaction.
`default_nettype none
module cop_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_en_i,
  input  wire logic [cop_pkg::IdW-1:0] pred_i,
  input  wire logic [cop_pkg::IdW-1:0] own_i,
  input  wire logic                    active_i,
  input  wire cop_pkg::query_t         query_i,
  output cop_pkg::query_t              query_o
);

  logic [cop_pkg::IdW-1:0] pred_q;
  logic [cop_pkg::IdW-1:0] own_q;
  logic                    valid_q;
  logic [cop_pkg::IdW-1:0] want_q;
  logic                    found_q;
  logic [cop_pkg::IdW-1:0] own_out_q;
  cop_pkg::query_t         query_d;
  logic                    hit;

  // Pair storage, written while the set loads.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pred_q <= pred_i;
      own_q  <= own_i;
    end
  end

  // The first active cell that matches claims the search.
  assign hit = active_i && (pred_q == query_i.want) && !query_i.found;

  always_comb begin
    query_d = query_i;
    if (hit) begin
      query_d.found = 1'b1;
      query_d.own   = own_q;
    end
  end

  // Hand the search on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= query_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q    <= query_d.want;
    found_q   <= query_d.found;
    own_out_q <= query_d.own;
  end

  assign query_o = '{valid: valid_q, want: want_q, found: found_q, own: own_out_q};

endmodule
`default_nettype wire

/* sv/chain_order_from_predecessor_pairs_unit.sv */
// Top level: pair cell chain and walk controller of the chain ordering block.
`default_nettype none
`include "assert_macros.svh"
// Pairs (pred_id, own_id) load one per cycle while busy is low into a chain of CAPACITY
// cells; a pair arriving while all cells are full is dropped. The pair marked last_pair
// starts the walk, and busy stays high until its final result. Each walk step sends one
// search transaction down the cell chain, one cell per cycle. A walk ends on a missing
// successor or once it has emitted as many ids as pairs are stored. The final result is
// shown in the cycle in which busy falls. Results appear on result_strobe_o for one cycle
// each and cannot be stalled by the receiver; last_out_o marks the final one, and
// no_head_o flags a set with no head pair.
module chain_order_from_predecessor_pairs_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [cop_pkg::IdW-1:0] pred_id_i,
  input  wire logic [cop_pkg::IdW-1:0] own_id_i,
  input  wire logic                    last_pair_i,
  output logic                         result_strobe_o,
  output logic [cop_pkg::IdW-1:0]      ordered_id_o,
  output logic                         last_out_o,
  output logic                         no_head_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINAL  = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  logic [cop_pkg::CntW-1:0]   count_q, count_d;
  logic [cop_pkg::CntW-1:0]   emitted_q, emitted_d;
  logic [cop_pkg::CntW-1:0]   emitted_inc;
  logic [cop_pkg::IdW-1:0]    want_q, want_d;
  logic [cop_pkg::IdW-1:0]    pend_q, pend_d;
  logic                       pend_valid_q, pend_valid_d;
  logic                       res_valid_q, res_valid_d;
  logic [cop_pkg::IdW-1:0]    res_id_q, res_id_d;
  logic                       res_last_q, res_last_d;
  logic                       res_nohead_q, res_nohead_d;
  logic                       accept;
  cop_pkg::query_t            chain [cop_pkg::CAPACITY+1];
  cop_pkg::query_t            tail;
  logic [cop_pkg::CAPACITY:0] chain_valid;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign emitted_inc = emitted_q + cop_pkg::CntW'(1);
  assign tail        = chain[cop_pkg::CAPACITY];

  // Search transaction entering the first cell.
  assign chain[0] = '{valid: (state_q == ST_LAUNCH), want: want_q, found: 1'b0, own: '0};

  // Row of pair cells.
  for (genvar i = 0; i < cop_pkg::CAPACITY; i++) begin : g_cell
    logic wr_en;
    logic active;

    assign wr_en  = accept && (count_q == cop_pkg::CntW'(i));
    assign active = (cop_pkg::CntW'(i) < count_q);

    cop_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en),
      .pred_i   (pred_id_i),
      .own_i    (own_id_i),
      .active_i (active),
      .query_i  (chain[i]),
      .query_o  (chain[i+1])
    );
  end

  for (genvar j = 0; j <= cop_pkg::CAPACITY; j++) begin : g_vld
    assign chain_valid[j] = chain[j].valid;
  end

  // Walk controller. A found id is held back one step, so that the final flag can go on it
  // once the next search has resolved or the pair count is reached.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    emitted_d    = emitted_q;
    want_d       = want_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    res_valid_d  = 1'b0;
    res_id_d     = res_id_q;
    res_last_d   = res_last_q;
    res_nohead_d = res_nohead_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < cop_pkg::CntW'(cop_pkg::CAPACITY)) begin
            count_d = count_q + cop_pkg::CntW'(1);
          end
          if (last_pair_i) begin
            want_d       = '0;
            pend_valid_d = 1'b0;
            emitted_d    = '0;
            state_d      = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (tail.valid) begin
          if (tail.found) begin
            if (pend_valid_q) begin
              res_valid_d  = 1'b1;
              res_id_d     = pend_q;
              res_last_d   = 1'b0;
              res_nohead_d = 1'b0;
            end
            pend_d       = tail.own;
            pend_valid_d = 1'b1;
            emitted_d    = emitted_inc;
            if (emitted_inc < count_q) begin
              want_d  = tail.own;
              state_d = ST_LAUNCH;
            end else begin
              state_d = ST_FINAL;
            end
          end else begin
            res_valid_d  = 1'b1;
            res_last_d   = 1'b1;
            res_id_d     = pend_valid_q ? pend_q : '0;
            res_nohead_d = !pend_valid_q;
            count_d      = '0;
            emitted_d    = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        res_valid_d  = 1'b1;
        res_id_d     = pend_q;
        res_last_d   = 1'b1;
        res_nohead_d = 1'b0;
        count_d      = '0;
        emitted_d    = '0;
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      emitted_q    <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      emitted_q    <= emitted_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    want_q       <= want_d;
    pend_q       <= pend_d;
    res_id_q     <= res_id_d;
    res_last_q   <= res_last_d;
    res_nohead_q <= res_nohead_d;
  end

  assign result_strobe_o = res_valid_q;
  assign ordered_id_o    = res_id_q;
  assign last_out_o      = res_last_q;
  assign no_head_o       = res_nohead_q;

  // Only one search transaction is ever in the chain.
  `COP_ASSERT(a_one_query, $onehot0(chain_valid), "more than one search in flight")
  // A search leaves the chain only while the controller waits for it.
  `COP_ASSERT(a_tail_wait, tail.valid |-> (state_q == ST_WAIT), "search result while not waiting")
  // A missing head ends the walk with a zero id.
  `COP_ASSERT(a_nohead_last, (res_valid_q && res_nohead_q) |-> (res_last_q && (res_id_q == '0)), "bad no-head result")
  // The walk never emits more ids than pairs stored.
  `COP_ASSERT(a_emit_bound, (emitted_q <= count_q), "emitted count beyond pair count")
  // A final result returns the block to idle.
  `COP_ASSERT(a_last_idle, (res_valid_q && res_last_q) |-> (state_q == ST_IDLE), "final result while busy")

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench for the chain ordering block: directed sets, full-store sets and random sets.
`timescale 1ns / 1ps

module testbench;

  localparam int Cap = cop_pkg::CAPACITY;
  localparam int IdW = cop_pkg::IdW;
  // Longest quiet stretch allowed: a walk step runs the whole cell chain.
  localparam int QuietLimit = 40 * (Cap + 2);
  // Cycles to watch for stray results once nothing is expected.
  localparam int TailCycles = 4 * (Cap + 2);
  localparam int RandomItems = 40;

  // Shapes of a pair set sent by the random and full-store tests.
  typedef enum int {
    SET_CLEAN,
    SET_BROKEN,
    SET_HEADLESS,
    SET_NOISE
  } set_shape_e;

  // One expected result of a walk.
  typedef struct {
    logic [IdW-1:0] ordered_id;
    logic           last_out;
    logic           no_head;
  } walk_result_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic [IdW-1:0] pred_id_i = '0;
  logic [IdW-1:0] own_id_i = '0;
  logic           last_pair_i = 1'b0;
  logic           result_strobe_o;
  logic [IdW-1:0] ordered_id_o;
  logic           last_out_o;
  logic           no_head_o;

  // Predictor copy of the pair store.
  logic [IdW-1:0] model_pred [Cap];
  logic [IdW-1:0] model_own [Cap];
  int             model_count = 0;

  walk_result_t   pending_ids [$];
  walk_result_t   oldest_id;
  int             error_count = 0;
  int             quiet_cycles = 0;
  bit             sender_burst = 1'b0;
  bit             used_ids [logic [IdW-1:0]];

  chain_order_from_predecessor_pairs_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .pred_id_i       (pred_id_i),
    .own_id_i        (own_id_i),
    .last_pair_i     (last_pair_i),
    .result_strobe_o (result_strobe_o),
    .ordered_id_o    (ordered_id_o),
    .last_out_o      (last_out_o),
    .no_head_o       (no_head_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Index of the first stored pair with the given predecessor, or -1.
  function automatic int first_successor(input logic [IdW-1:0] want);
    for (int i = 0; i < model_count; i++) begin
      if (model_pred[i] == want) return i;
    end
    return -1;
  endfunction

  // Store one accepted pair and, on the last pair, queue the ids of the walk.
  function automatic void predict_walk(input logic [IdW-1:0] pred, input logic [IdW-1:0] own,
                                       input logic last);
    walk_result_t   walk [$];
    int             idx;
    int             emitted;
    logic [IdW-1:0] cur;
    if (model_count < Cap) begin
      model_pred[model_count] = pred;
      model_own[model_count] = own;
      model_count++;
    end
    if (!last) return;
    idx = first_successor('0);
    if (idx < 0) begin
      walk.push_back('{'0, 1'b1, 1'b1});
    end else begin
      cur = model_own[idx];
      walk.push_back('{cur, 1'b0, 1'b0});
      emitted = 1;
      while (emitted < model_count) begin
        idx = first_successor(cur);
        if (idx < 0) break;
        cur = model_own[idx];
        walk.push_back('{cur, 1'b0, 1'b0});
        emitted++;
      end
      walk[walk.size() - 1].last_out = 1'b1;
    end
    foreach (walk[i]) pending_ids.push_back(walk[i]);
    model_count = 0;
  endfunction

  // A nonzero id not yet used in the current set.
  function automatic logic [IdW-1:0] fresh_id();
    logic [IdW-1:0] v;
    do begin
      v = IdW'($urandom_range(1, (1 << IdW) - 1));
    end while (used_ids.exists(v));
    used_ids[v] = 1'b1;
    return v;
  endfunction

  // Send one pair as a transaction and record it once it is accepted.
  task automatic send_pair(input logic [IdW-1:0] pred, input logic [IdW-1:0] own,
                           input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    pred_id_i <= pred;
    own_id_i <= own;
    last_pair_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_walk(pred, own, last);
  endtask

  // Hold the sender off until every queued result has arrived.
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_ids.size() != 0) @(posedge clk_i);
  endtask

  // Send a set of n stored pairs in shuffled order, then dropped pairs if the store is full.
  task automatic send_set(input int n, input set_shape_e shape, input int dropped);
    logic [IdW-1:0] ids [$];
    logic [IdW-1:0] preds [$];
    int             order [$];
    int             j;
    int             tmp;
    logic           last;
    used_ids.delete();
    for (int i = 0; i < n; i++) ids.push_back(fresh_id());
    for (int i = 0; i < n; i++) begin
      preds.push_back(i == 0 ? '0 : ids[i - 1]);
      order.push_back(i);
    end
    case (shape)
      SET_BROKEN: begin
        if (n > 1) preds[$urandom_range(1, n - 1)] = fresh_id();
      end
      SET_HEADLESS: begin
        preds[0] = fresh_id();
      end
      SET_NOISE: begin
        for (int i = 0; i < n; i++) begin
          preds[i] = ($urandom_range(0, 3) == 0) ? '0 : IdW'($urandom);
          ids[i] = ($urandom_range(0, 3) == 0) ? preds[$urandom_range(0, n - 1)] : IdW'($urandom);
        end
      end
      default: begin
      end
    endcase
    // Shuffle the arrival order so the head sits anywhere in the store.
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      last = (dropped == 0) && (i == n - 1);
      send_pair(preds[order[i]], ids[order[i]], last);
    end
    for (int i = 0; i < dropped; i++) begin
      send_pair(($urandom_range(0, 1) == 0) ? '0 : IdW'($urandom), IdW'($urandom),
                i == dropped - 1);
    end
  endtask

  // Single pairs with and without a head, at the extremes of the id range.
  task automatic test_single_pairs();
    send_pair('0, '1, 1'b1);
    send_pair('1, 16'h0001, 1'b1);
    send_pair(16'h8000, '0, 1'b1);
  endtask

  // A shuffled chain of four, then a chain that breaks after its head.
  task automatic test_chain_walks();
    send_pair(16'h0030, 16'h0040, 1'b0);
    send_pair(16'h0000, 16'h0010, 1'b0);
    send_pair(16'h0020, 16'h0030, 1'b0);
    send_pair(16'h0010, 16'h0020, 1'b1);
    send_pair(16'h0000, 16'h0005, 1'b0);
    send_pair(16'h0007, 16'h0008, 1'b1);
  endtask

  // Loops and repeated ids: the first matching pair wins and the walk is capped.
  task automatic test_cycles_and_duplicates();
    send_pair(16'h0000, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'h0002, 1'b0);
    send_pair(16'h0002, 16'h0001, 1'b0);
    send_pair(16'h0000, 16'h0009, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'haaaa, 16'h5555, 1'b0);
    send_pair(16'h0000, 16'haaaa, 1'b1);
    send_pair(16'hffff, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hffff, 1'b1);
  endtask

  // Full store: pairs past capacity are dropped, and a dropped last pair still starts the walk.
  task automatic test_store_full();
    sender_burst = 1'b0;
    send_set(Cap, SET_CLEAN, 2);
    wait_results_drained();
  endtask

  // Random sets, mostly well-formed chains with random ids, some broken, headless or noisy.
  task automatic test_random_sets();
    int         sent;
    int         size;
    int         pick;
    set_shape_e shape;
    sent = 0;
    while (sent < RandomItems) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      if (pick < 6) shape = SET_CLEAN;
      else if (pick < 8) shape = SET_BROKEN;
      else if (pick < 9) shape = SET_HEADLESS;
      else shape = SET_NOISE;
      sender_burst = ($urandom_range(0, 3) == 0);
      send_set(size, shape, 0);
      sent += size;
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end
  endtask

  // Compare each result transaction with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_ids.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %h last %b no_head %b",
                 $time, ordered_id_o, last_out_o, no_head_o);
        error_count++;
      end else begin
        oldest_id = pending_ids.pop_front();
        if (ordered_id_o !== oldest_id.ordered_id) begin
          $display("%0t: ordered_id mismatch, expected %h, actual %h",
                   $time, oldest_id.ordered_id, ordered_id_o);
          error_count++;
        end
        if (last_out_o !== oldest_id.last_out) begin
          $display("%0t: last_out mismatch, expected %b, actual %b",
                   $time, oldest_id.last_out, last_out_o);
          error_count++;
        end
        if (no_head_o !== oldest_id.no_head) begin
          $display("%0t: no_head mismatch, expected %b, actual %b",
                   $time, oldest_id.no_head, no_head_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction on either side.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_ids.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_pairs();
    test_chain_walks();
    test_cycles_and_duplicates();
    wait_results_drained();
    test_store_full();
    test_random_sets();
    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
